// ----- rtl/core/source_text_tokenizer_assert.svh -----
// assertion macros shared by the checker
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define TKZ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// next-cycle implication
`define TKZ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

// ----- rtl/core/tkz_pkg.sv -----
`default_nettype none
package tkz_pkg;

    localparam int POSITION_BITS_DEF = 20;
    localparam int LENGTH_BITS_DEF   = 16;
    localparam int MAX_RESULTS       = 5;
    localparam int RES_CNT_W         = 3;
    localparam int RK_W              = 2;
    localparam int CLS_W             = 6;
    localparam int QUEUE_DEPTH       = 4;
    localparam int KW_COUNT          = 26;
    localparam int KW_MAX_LEN        = 9;
    localparam int KW_IDX_W          = 4;

    localparam logic [RK_W-1:0] RK_TOKEN = 2'd0;
    localparam logic [RK_W-1:0] RK_ERROR = 2'd1;
    localparam logic [RK_W-1:0] RK_END   = 2'd2;

    localparam logic [CLS_W-1:0] CLS_ZERO      = 6'd0;
    localparam logic [CLS_W-1:0] CLS_IDENT     = 6'd23;
    localparam logic [CLS_W-1:0] CLS_NUMBER    = 6'd24;
    localparam logic [CLS_W-1:0] CLS_LPAREN    = 6'd25;
    localparam logic [CLS_W-1:0] CLS_RPAREN    = 6'd26;
    localparam logic [CLS_W-1:0] CLS_SEMI      = 6'd27;
    localparam logic [CLS_W-1:0] CLS_LBRACK    = 6'd28;
    localparam logic [CLS_W-1:0] CLS_RBRACK    = 6'd29;
    localparam logic [CLS_W-1:0] CLS_LBRACE    = 6'd30;
    localparam logic [CLS_W-1:0] CLS_RBRACE    = 6'd31;
    localparam logic [CLS_W-1:0] CLS_ARITH     = 6'd32;
    localparam logic [CLS_W-1:0] CLS_INCR      = 6'd33;
    localparam logic [CLS_W-1:0] CLS_ASSIGN_OP = 6'd34;
    localparam logic [CLS_W-1:0] CLS_COMPARE   = 6'd35;
    localparam logic [CLS_W-1:0] CLS_LOGIC     = 6'd36;
    localparam logic [CLS_W-1:0] CLS_DOT       = 6'd37;
    localparam logic [CLS_W-1:0] CLS_ASSIGN    = 6'd38;
    localparam logic [CLS_W-1:0] CLS_NONE      = 6'd63;

    typedef enum logic [1:0] {
        WK_NONE,
        WK_DIGITS,
        WK_IDENT,
        WK_BAD
    } t_word_kind;

    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
        72'("let"), 72'("constant"), 72'("const"), 72'("double"), 72'("long"),
        72'("bool"), 72'("true"), 72'("false"), 72'("Enum"), 72'("Interface"),
        72'("Array"), 72'("for"), 72'("while"), 72'("i8"), 72'("i16"),
        72'("i32"), 72'("i64"), 72'("i128"), 72'("ui8"), 72'("ui16"),
        72'("ui32"), 72'("ui64"), 72'("ui128"), 72'("Function"), 72'("Class"),
        72'("Struct")
    };

    localparam int KW_LEN [KW_COUNT] = '{
        3, 8, 5, 6, 4, 4, 4, 5, 4, 9, 5, 3, 5, 2, 3, 3, 3, 4, 3, 4, 4, 4, 5, 8, 5, 6
    };

    localparam logic [CLS_W-1:0] KW_CLASS [KW_COUNT] = '{
        6'd0, 6'd1, 6'd1, 6'd2, 6'd3, 6'd4, 6'd4, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9,
        6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19,
        6'd20, 6'd21, 6'd22
    };

    function automatic int bundle_bits(input int pos_bits, input int len_bits);
        return RES_CNT_W + MAX_RESULTS * (RK_W + CLS_W + pos_bits + len_bits);
    endfunction

    function automatic logic [7:0] kw_char(input int k, input logic [KW_IDX_W-1:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (int'(idx) < KW_LEN[k]) begin
            ch = KW_TEXT[k][8*(KW_LEN[k]-1-int'(idx)) +: 8];
        end
        return ch;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h41:8'h5a], [8'h61:8'h7a]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0d]};
    endfunction

    function automatic logic may_start_pair(input logic [7:0] c);
        return c inside {"+", "-", "*", "/", "=", "!", "<", ">", "&", "|"};
    endfunction

    function automatic logic [CLS_W-1:0] single_class(input logic [7:0] c);
        logic [CLS_W-1:0] r;
        case (c)
            "(": r = CLS_LPAREN;
            ")": r = CLS_RPAREN;
            ";": r = CLS_SEMI;
            "[": r = CLS_LBRACK;
            "]": r = CLS_RBRACK;
            "{": r = CLS_LBRACE;
            "}": r = CLS_RBRACE;
            "+", "-", "*", "/": r = CLS_ARITH;
            "<", ">": r = CLS_COMPARE;
            "!": r = CLS_LOGIC;
            ".": r = CLS_DOT;
            "=": r = CLS_ASSIGN;
            default: r = CLS_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [CLS_W-1:0] pair_class(input logic [7:0] a, input logic [7:0] b);
        logic [CLS_W-1:0] r;
        r = CLS_NONE;
        if (a == "+" && b == "+") begin
            r = CLS_INCR;
        end else if (b == "=" && a inside {"+", "-", "*", "/"}) begin
            r = CLS_ASSIGN_OP;
        end else if (b == "=" && a inside {"=", "!", "<", ">"}) begin
            r = CLS_COMPARE;
        end else if ((a == "&" && b == "&") || (a == "|" && b == "|")) begin
            r = CLS_LOGIC;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/tkz_front.sv -----
`default_nettype none
module tkz_front
    import tkz_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
    localparam int BUNDLE_W     = bundle_bits(POSITION_BITS, LENGTH_BITS)
)(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_char_code,
    input  logic                i_source_last,
    input  logic                i_queue_full,
    output logic                o_push,
    output logic [BUNDLE_W-1:0] o_bundle
);

    typedef struct packed {
        logic [RK_W-1:0]          kind;
        logic [CLS_W-1:0]         cls;
        logic [POSITION_BITS-1:0] start;
        logic [LENGTH_BITS-1:0]   len;
    } t_result;

    typedef struct packed {
        logic [RES_CNT_W-1:0]           cnt;
        t_result [MAX_RESULTS-1:0]      res;
    } t_bundle;

    typedef struct packed {
        logic [7:0]               held_byte;
        logic                     held_valid;
        t_word_kind               word_kind;
        logic [POSITION_BITS-1:0] word_start;
        logic [LENGTH_BITS-1:0]   word_len;
        logic [KW_COUNT-1:0]      alive;
        logic                     pend_valid;
        logic [POSITION_BITS-1:0] pend_start;
        logic [LENGTH_BITS-1:0]   pend_len;
        logic [POSITION_BITS-1:0] pos;
        logic                     halted;
    } t_state;

    typedef struct packed {
        t_state  st;
        t_bundle bnd;
    } t_work;

    t_state  r_st;
    t_state  n_st;
    t_bundle n_bundle;
    logic    accept;

    function automatic t_state f_clear();
        t_state s;
        s.held_byte  = '0;
        s.held_valid = 1'b0;
        s.word_kind  = WK_NONE;
        s.word_start = '0;
        s.word_len   = '0;
        s.alive      = '1;
        s.pend_valid = 1'b0;
        s.pend_start = '0;
        s.pend_len   = '0;
        s.pos        = '0;
        s.halted     = 1'b0;
        return s;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] f_sat(input logic [LENGTH_BITS-1:0] a,
                                                     input logic [LENGTH_BITS-1:0] b);
        logic [LENGTH_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LENGTH_BITS] ? '1 : s[LENGTH_BITS-1:0];
    endfunction

    function automatic t_work f_emit(input t_work w, input logic [RK_W-1:0] kind,
                                     input logic [CLS_W-1:0] cls,
                                     input logic [POSITION_BITS-1:0] start,
                                     input logic [LENGTH_BITS-1:0] len);
        t_work o;
        o = w;
        if (!o.st.halted && o.bnd.cnt < RES_CNT_W'(MAX_RESULTS)) begin
            o.bnd.res[o.bnd.cnt].kind  = kind;
            o.bnd.res[o.bnd.cnt].cls   = cls;
            o.bnd.res[o.bnd.cnt].start = start;
            o.bnd.res[o.bnd.cnt].len   = len;
            o.bnd.cnt = o.bnd.cnt + 1'b1;
            if (kind == RK_ERROR) begin
                o.st.halted = 1'b1;
            end
        end
        return o;
    endfunction

    function automatic t_work f_flush(input t_work w);
        t_work o;
        o = w;
        if (o.st.pend_valid) begin
            o = f_emit(o, RK_TOKEN, CLS_NUMBER, o.st.pend_start, o.st.pend_len);
            o.st.pend_valid = 1'b0;
        end
        return o;
    endfunction

    function automatic t_work f_end_word(input t_work w);
        t_work            o;
        logic [CLS_W-1:0] cls;
        o   = w;
        cls = CLS_IDENT;
        case (o.st.word_kind)
            WK_DIGITS: begin
                if (o.st.pend_valid) begin
                    o.st.pend_len = f_sat(o.st.pend_len, o.st.word_len);
                end else begin
                    o.st.pend_valid = 1'b1;
                    o.st.pend_start = o.st.word_start;
                    o.st.pend_len   = o.st.word_len;
                end
            end
            WK_IDENT: begin
                o = f_flush(o);
                for (int k = 0; k < KW_COUNT; k++) begin
                    if (o.st.alive[k] && 32'(o.st.word_len) == KW_LEN[k]) begin
                        cls = KW_CLASS[k];
                    end
                end
                o = f_emit(o, RK_TOKEN, cls, o.st.word_start, o.st.word_len);
            end
            WK_BAD: begin
                o = f_flush(o);
                o = f_emit(o, RK_ERROR, CLS_ZERO, o.st.word_start, o.st.word_len);
            end
            default: ;
        endcase
        o.st.word_kind = WK_NONE;
        o.st.word_len  = '0;
        o.st.alive     = '1;
        return o;
    endfunction

    function automatic t_work f_append(input t_work w, input logic [7:0] c,
                                       input logic [POSITION_BITS-1:0] pos);
        t_work o;
        logic  dig;
        logic  idst;
        o    = w;
        dig  = is_digit(c);
        idst = is_letter(c) || c == "_";
        if (o.st.word_kind == WK_NONE) begin
            o.st.word_kind  = dig ? WK_DIGITS : (idst ? WK_IDENT : WK_BAD);
            o.st.word_start = pos;
            o.st.word_len   = '0;
            o.st.alive      = '1;
        end else if (o.st.word_kind == WK_DIGITS && !dig) begin
            o.st.word_kind = WK_BAD;
        end else if (o.st.word_kind == WK_IDENT && !(dig || idst)) begin
            o.st.word_kind = WK_BAD;
        end
        for (int k = 0; k < KW_COUNT; k++) begin
            if (32'(o.st.word_len) >= KW_LEN[k] ||
                kw_char(k, o.st.word_len[KW_IDX_W-1:0]) != c) begin
                o.st.alive[k] = 1'b0;
            end
        end
        if (o.st.word_len != '1) begin
            o.st.word_len = o.st.word_len + 1'b1;
        end
        return o;
    endfunction

    function automatic t_work f_resolve(input t_work w, input logic [POSITION_BITS-1:0] pos);
        t_work            o;
        logic [CLS_W-1:0] sc;
        o  = w;
        sc = single_class(o.st.held_byte);
        if (o.st.held_valid) begin
            o.st.held_valid = 1'b0;
            if (sc == CLS_NONE) begin
                o = f_append(o, o.st.held_byte, pos);
            end else begin
                o = f_end_word(o);
                o = f_flush(o);
                o = f_emit(o, RK_TOKEN, sc, pos, LENGTH_BITS'(1));
            end
        end
        return o;
    endfunction

    always_comb begin
        t_work                    w;
        logic [CLS_W-1:0]         pc;
        logic [CLS_W-1:0]         sc;
        logic [POSITION_BITS-1:0] pos;
        logic [POSITION_BITS-1:0] pos_n;
        w.st    = r_st;
        w.bnd   = '0;
        pos     = r_st.pos;
        pos_n   = r_st.pos + 1'b1;
        pc      = pair_class(r_st.held_byte, i_char_code);
        sc      = single_class(i_char_code);
        if (r_st.held_valid && pc != CLS_NONE) begin
            w.st.held_valid = 1'b0;
            w = f_end_word(w);
            w = f_flush(w);
            w = f_emit(w, RK_TOKEN, pc, pos - 1'b1, LENGTH_BITS'(2));
        end else begin
            w = f_resolve(w, pos - 1'b1);
            if (is_space(i_char_code)) begin
                w = f_end_word(w);
            end else if (may_start_pair(i_char_code)) begin
                w.st.held_valid = 1'b1;
                w.st.held_byte  = i_char_code;
            end else if (sc != CLS_NONE) begin
                w = f_end_word(w);
                w = f_flush(w);
                w = f_emit(w, RK_TOKEN, sc, pos, LENGTH_BITS'(1));
            end else if (i_char_code == "," || i_char_code == ":") begin
                w = f_end_word(w);
                w = f_flush(w);
                w = f_emit(w, RK_ERROR, CLS_ZERO, pos, LENGTH_BITS'(1));
            end else begin
                w = f_append(w, i_char_code, pos);
            end
        end
        w.st.pos = pos_n;
        if (i_source_last) begin
            w = f_resolve(w, pos);
            w = f_end_word(w);
            w = f_flush(w);
            w = f_emit(w, RK_END, CLS_ZERO, pos_n, '0);
            if (!w.st.halted) begin
                w.st = f_clear();
            end
        end
        n_st     = w.st;
        n_bundle = w.bnd;
    end

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && !r_st.halted && n_bundle.cnt != '0;
    assign o_bundle   = n_bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= f_clear();
        end else if (accept && !r_st.halted) begin
            r_st <= n_st;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/tkz_queue.sv -----
`default_nettype none
module tkz_queue
    import tkz_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= f_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= f_next(r_rd);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/tkz_back.sv -----
`default_nettype none
module tkz_back
    import tkz_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
    localparam int BUNDLE_W     = bundle_bits(POSITION_BITS, LENGTH_BITS)
)(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [BUNDLE_W-1:0]      i_head,
    input  logic                     i_empty,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [RK_W-1:0]          o_result_kind,
    output logic [CLS_W-1:0]         o_token_class,
    output logic [POSITION_BITS-1:0] o_token_start,
    output logic [LENGTH_BITS-1:0]   o_token_length,
    output logic                     o_run_last
);

    typedef struct packed {
        logic [RK_W-1:0]          kind;
        logic [CLS_W-1:0]         cls;
        logic [POSITION_BITS-1:0] start;
        logic [LENGTH_BITS-1:0]   len;
    } t_result;

    typedef struct packed {
        logic [RES_CNT_W-1:0]      cnt;
        t_result [MAX_RESULTS-1:0] res;
    } t_bundle;

    t_bundle              r_bund;
    logic [RES_CNT_W-1:0] r_idx;
    logic                 r_busy;
    t_result              cur;
    logic                 take;
    logic                 at_end;
    logic                 load;

    assign take   = r_busy && i_out_ready;
    assign at_end = r_idx == r_bund.cnt - 1'b1;
    assign load   = !r_busy || (take && at_end);
    assign o_pop  = load && !i_empty;
    assign cur    = r_bund.res[r_idx];

    assign o_out_valid    = r_busy;
    assign o_result_kind  = cur.kind;
    assign o_token_class  = cur.cls;
    assign o_token_start  = cur.start;
    assign o_token_length = cur.len;
    assign o_run_last     = at_end;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bund <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= !i_empty;
            r_idx  <= '0;
        end else if (take) begin
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/source_text_tokenizer.sv -----
// source text tokenizer
// input channel: one source byte per transaction (i_char_code, i_source_last),
// handshake i_in_valid / o_in_ready. output channel: one result per transaction
// (kind, class, start, length, run_last), handshake o_out_valid / i_out_ready.
// a byte is decoded in the cycle it is taken; its results (zero to five), if any, go
// as one bundle into a four-bundle queue and leave one per cycle from a registered
// stage while the receiver is ready. the results of a byte are written into the
// queue and then loaded into the registered output stage before they are offered.
// throughput: one byte per cycle while the queue is not full; bursts of results
// are absorbed by the queue and o_in_ready drops only when the queue is full.
// run_last marks the final result of one byte. end of source resets the stream
// state so a new source can follow.
// an error result halts the block: further bytes are taken and dropped until
// reset. reset (synchronous, active low) clears the queue and stream state.
// a stalled receiver holds the current result stable until taken.
`default_nettype none
module source_text_tokenizer
    import tkz_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF
)(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [7:0]               i_char_code,
    input  logic                     i_source_last,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [RK_W-1:0]          o_result_kind,
    output logic [CLS_W-1:0]         o_token_class,
    output logic [POSITION_BITS-1:0] o_token_start,
    output logic [LENGTH_BITS-1:0]   o_token_length,
    output logic                     o_run_last
);

    localparam int BUNDLE_W = bundle_bits(POSITION_BITS, LENGTH_BITS);

    logic                push;
    logic                pop;
    logic                full;
    logic                empty;
    logic [BUNDLE_W-1:0] wr_bundle;
    logic [BUNDLE_W-1:0] rd_bundle;

    tkz_front #(
        .POSITION_BITS(POSITION_BITS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_char_code  (i_char_code),
        .i_source_last(i_source_last),
        .i_queue_full (full),
        .o_push       (push),
        .o_bundle     (wr_bundle)
    );

    tkz_queue #(
        .WIDTH(BUNDLE_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (wr_bundle),
        .o_full (full),
        .i_pop  (pop),
        .o_data (rd_bundle),
        .o_empty(empty)
    );

    tkz_back #(
        .POSITION_BITS(POSITION_BITS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (rd_bundle),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_kind (o_result_kind),
        .o_token_class (o_token_class),
        .o_token_start (o_token_start),
        .o_token_length(o_token_length),
        .o_run_last    (o_run_last)
    );

endmodule
`default_nettype wire

// ----- rtl/core/tkz_checker.sv -----
`default_nettype none
`include "source_text_tokenizer_assert.svh"
module tkz_checker
    import tkz_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [RK_W-1:0]        i_result_kind,
    input logic [CLS_W-1:0]       i_token_class,
    input logic [LENGTH_BITS-1:0] i_token_length,
    input logic                   i_run_last
);

    // a stalled result stays offered
    `TKZ_ASSERT_NXT(a_hold_valid, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    `TKZ_ASSERT_IMP(a_class_zero, i_clk, i_rst_n, i_out_valid && i_result_kind != RK_TOKEN, i_token_class == CLS_ZERO)

    `TKZ_ASSERT_IMP(a_end_last, i_clk, i_rst_n, i_out_valid && i_result_kind == RK_END, i_run_last && i_token_length == '0)

    // nothing follows an error within its byte
    `TKZ_ASSERT_IMP(a_error_last, i_clk, i_rst_n, i_out_valid && i_result_kind == RK_ERROR, i_run_last)

endmodule

bind source_text_tokenizer tkz_checker #(
    .LENGTH_BITS(LENGTH_BITS)
) u_tkz_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .i_result_kind (o_result_kind),
    .i_token_class (o_token_class),
    .i_token_length(o_token_length),
    .i_run_last    (o_run_last)
);
`default_nettype wire

// ----- sim/source_text_tokenizer_tb.sv -----
`timescale 1ns / 100ps

module source_text_tokenizer_tb;
    import tkz_pkg::*;

    localparam int POS_W     = 20;
    localparam int LEN_W     = 16;
    localparam int ITEMS     = 410;
    localparam int STALL_LEN = 300;
    localparam int LIMIT     = 200000;

    typedef struct packed {
        logic [RK_W-1:0]  kind;
        logic [CLS_W-1:0] cls;
        logic [POS_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic             run_last;
    } t_token;

    class token_board;
        localparam logic [CLS_W-1:0] T_LET = 6'd0, T_CONST = 6'd1, T_DOUBLE = 6'd2;
        localparam logic [CLS_W-1:0] T_LONG = 6'd3, T_BOOL = 6'd4, T_ENUM = 6'd5;
        localparam logic [CLS_W-1:0] T_IFACE = 6'd6, T_ARRAY = 6'd7, T_FOR = 6'd8;
        localparam logic [CLS_W-1:0] T_WHILE = 6'd9, T_I8 = 6'd10, T_I16 = 6'd11;
        localparam logic [CLS_W-1:0] T_I32 = 6'd12, T_I64 = 6'd13, T_I128 = 6'd14;
        localparam logic [CLS_W-1:0] T_UI8 = 6'd15, T_UI16 = 6'd16, T_UI32 = 6'd17;
        localparam logic [CLS_W-1:0] T_UI64 = 6'd18, T_UI128 = 6'd19, T_FUNC = 6'd20;
        localparam logic [CLS_W-1:0] T_CLASS = 6'd21, T_STRUCT = 6'd22;

        t_token           pending[$];
        t_token           burst[$];
        int               mismatches;
        logic [7:0]       held_byte;
        bit               held_valid;
        t_word_kind       word_kind;
        logic [POS_W-1:0] word_start;
        logic [LEN_W-1:0] word_len;
        string            word_text;
        bit               num_valid;
        logic [POS_W-1:0] num_start;
        logic [LEN_W-1:0] num_len;
        logic [POS_W-1:0] byte_pos;
        bit               halted;

        function new();
            clear_stream();
            halted = 0;
            mismatches = 0;
        endfunction

        function void clear_stream();
            held_byte = 8'h00;
            held_valid = 0;
            word_kind = WK_NONE;
            word_start = '0;
            word_len = '0;
            word_text = "";
            num_valid = 0;
            num_start = '0;
            num_len = '0;
            byte_pos = '0;
        endfunction

        function bit digit_ch(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit letter_ch(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit blank_ch(logic [7:0] c);
            return c == " " || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function bit opener(logic [7:0] c);
            return c == "+" || c == "-" || c == "*" || c == "/" || c == "=" ||
                   c == "!" || c == "<" || c == ">" || c == "&" || c == "|";
        endfunction

        function logic [CLS_W-1:0] lone_code(logic [7:0] c);
            case (c)
                "(": return CLS_LPAREN;
                ")": return CLS_RPAREN;
                ";": return CLS_SEMI;
                "[": return CLS_LBRACK;
                "]": return CLS_RBRACK;
                "{": return CLS_LBRACE;
                "}": return CLS_RBRACE;
                "+", "-", "*", "/": return CLS_ARITH;
                "<", ">": return CLS_COMPARE;
                "!": return CLS_LOGIC;
                ".": return CLS_DOT;
                "=": return CLS_ASSIGN;
                default: return CLS_NONE;
            endcase
        endfunction

        function logic [CLS_W-1:0] pair_code(logic [7:0] a, logic [7:0] b);
            if (a == "+" && b == "+") return CLS_INCR;
            if (b == "=" && (a == "+" || a == "-" || a == "*" || a == "/")) return CLS_ASSIGN_OP;
            if (b == "=" && (a == "=" || a == "!" || a == "<" || a == ">")) return CLS_COMPARE;
            if ((a == "&" && b == "&") || (a == "|" && b == "|")) return CLS_LOGIC;
            return CLS_NONE;
        endfunction

        function logic [CLS_W-1:0] word_code(string w);
            case (w)
                "let": return T_LET;
                "constant", "const": return T_CONST;
                "double": return T_DOUBLE;
                "long": return T_LONG;
                "bool", "true", "false": return T_BOOL;
                "Enum": return T_ENUM;
                "Interface": return T_IFACE;
                "Array": return T_ARRAY;
                "for": return T_FOR;
                "while": return T_WHILE;
                "i8": return T_I8;
                "i16": return T_I16;
                "i32": return T_I32;
                "i64": return T_I64;
                "i128": return T_I128;
                "ui8": return T_UI8;
                "ui16": return T_UI16;
                "ui32": return T_UI32;
                "ui64": return T_UI64;
                "ui128": return T_UI128;
                "Function": return T_FUNC;
                "Class": return T_CLASS;
                "Struct": return T_STRUCT;
                default: return CLS_IDENT;
            endcase
        endfunction

        function logic [LEN_W-1:0] sat_sum(logic [LEN_W-1:0] a, logic [LEN_W-1:0] b);
            logic [LEN_W:0] s;
            s = a + b;
            return s[LEN_W] ? '1 : s[LEN_W-1:0];
        endfunction

        function void emit(logic [RK_W-1:0] kind, logic [CLS_W-1:0] cls,
                           logic [POS_W-1:0] start, logic [LEN_W-1:0] len);
            t_token r;
            if (halted || burst.size() >= MAX_RESULTS) return;
            r.kind = kind;
            r.cls = cls;
            r.start = start;
            r.len = len;
            r.run_last = 0;
            burst = {burst, r};
            if (kind == RK_ERROR) halted = 1;
        endfunction

        function void flush_number();
            if (num_valid) begin
                emit(RK_TOKEN, CLS_NUMBER, num_start, num_len);
                num_valid = 0;
            end
        endfunction

        function void end_word();
            if (word_kind == WK_DIGITS) begin
                if (num_valid) begin
                    num_len = sat_sum(num_len, word_len);
                end else begin
                    num_valid = 1;
                    num_start = word_start;
                    num_len = word_len;
                end
            end else if (word_kind == WK_IDENT) begin
                flush_number();
                emit(RK_TOKEN, word_code(word_text), word_start, word_len);
            end else if (word_kind == WK_BAD) begin
                flush_number();
                emit(RK_ERROR, CLS_ZERO, word_start, word_len);
            end
            word_kind = WK_NONE;
            word_len = '0;
            word_text = "";
        endfunction

        function void append_char(logic [7:0] c, logic [POS_W-1:0] p);
            string one;
            bit idc;
            idc = letter_ch(c) || digit_ch(c) || c == "_";
            if (word_kind == WK_NONE) begin
                word_kind = digit_ch(c) ? WK_DIGITS :
                            ((letter_ch(c) || c == "_") ? WK_IDENT : WK_BAD);
                word_start = p;
                word_len = '0;
                word_text = "";
            end else if (word_kind == WK_DIGITS && !digit_ch(c)) begin
                word_kind = WK_BAD;
            end else if (word_kind == WK_IDENT && !idc) begin
                word_kind = WK_BAD;
            end
            if (word_text.len() < 10) begin
                one = " ";
                one.putc(0, c);
                word_text = {word_text, one};
            end
            if (word_len != '1) word_len = word_len + 1'b1;
        endfunction

        function void resolve_held();
            logic [POS_W-1:0] p;
            logic [CLS_W-1:0] k;
            if (!held_valid) return;
            held_valid = 0;
            p = byte_pos - 1'b1;
            k = lone_code(held_byte);
            if (k == CLS_NONE) begin
                append_char(held_byte, p);
            end else begin
                end_word();
                flush_number();
                emit(RK_TOKEN, k, p, 1);
            end
        endfunction

        function void note_byte(logic [7:0] c, bit last);
            logic [POS_W-1:0] p;
            logic [CLS_W-1:0] k;
            bit done;
            t_token r;
            burst.delete();
            p = byte_pos;
            done = 0;
            if (halted) return;
            if (held_valid) begin
                k = pair_code(held_byte, c);
                if (k != CLS_NONE) begin
                    held_valid = 0;
                    end_word();
                    flush_number();
                    emit(RK_TOKEN, k, p - 1'b1, 2);
                    done = 1;
                end else begin
                    resolve_held();
                end
            end
            if (!done) begin
                if (blank_ch(c)) begin
                    end_word();
                end else if (opener(c)) begin
                    held_valid = 1;
                    held_byte = c;
                end else if (lone_code(c) != CLS_NONE) begin
                    end_word();
                    flush_number();
                    emit(RK_TOKEN, lone_code(c), p, 1);
                end else if (c == "," || c == ":") begin
                    end_word();
                    flush_number();
                    emit(RK_ERROR, CLS_ZERO, p, 1);
                end else begin
                    append_char(c, p);
                end
            end
            byte_pos = p + 1'b1;
            if (last) begin
                resolve_held();
                end_word();
                flush_number();
                emit(RK_END, CLS_ZERO, byte_pos, 0);
                if (!halted) clear_stream();
            end
            if (burst.size() > 0) begin
                r = burst[burst.size()-1];
                r.run_last = 1;
                burst[burst.size()-1] = r;
            end
            for (int i = 0; i < burst.size(); i++) pending = {pending, burst[i]};
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(logic [RK_W-1:0] kind, logic [CLS_W-1:0] cls,
                          logic [POS_W-1:0] start, logic [LEN_W-1:0] len, logic rl);
            t_token e;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d class %0d start %0d",
                                          kind, cls, start));
                return;
            end
            e = pending.pop_front();
            if (kind !== e.kind)
                report_mismatch($sformatf("kind %0d, want %0d", kind, e.kind));
            if (cls !== e.cls)
                report_mismatch($sformatf("class %0d, want %0d", cls, e.cls));
            if (start !== e.start)
                report_mismatch($sformatf("start %0d, want %0d", start, e.start));
            if (len !== e.len)
                report_mismatch($sformatf("length %0d, want %0d", len, e.len));
            if (rl !== e.run_last)
                report_mismatch($sformatf("run_last %0d, want %0d", rl, e.run_last));
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic [7:0]       char_code = 8'h00;
    logic             source_last = 1'b0;
    logic             out_ready = 1'b0;
    logic             in_ready;
    logic             out_valid;
    logic [RK_W-1:0]  result_kind;
    logic [CLS_W-1:0] token_class;
    logic [POS_W-1:0] token_start;
    logic [LEN_W-1:0] token_length;
    logic             run_last;

    token_board sb;
    int send_idle = 27;
    int recv_idle = 60;
    int bytes_sent = 0;
    int stall_ticket = 0;
    int stall_seen = 0;
    int stall_left = 0;
    int cycle_count = 0;

    string kw_list [26] = '{"let", "constant", "const", "double", "long", "bool", "true",
        "false", "Enum", "Interface", "Array", "for", "while", "i8", "i16", "i32", "i64",
        "i128", "ui8", "ui16", "ui32", "ui64", "ui128", "Function", "Class", "Struct"};
    string op_pairs [11] = '{"++", "==", "!=", "<=", ">=", "+=", "-=", "*=", "/=",
        "&&", "||"};
    string op_singles = "()[]{}+-*/=;<>.!";
    string blanks = " \t\n\r\v\f";
    string id_chars = "abcxyzABCXYZ_0123456789";

    source_text_tokenizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_char_code    (char_code),
        .i_source_last  (source_last),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_result_kind  (result_kind),
        .o_token_class  (token_class),
        .o_token_start  (token_start),
        .o_token_length (token_length),
        .o_run_last     (run_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver side, with its own long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready)
                sb.check_result(result_kind, token_class, token_start, token_length, run_last);
            if (stall_ticket != stall_seen) begin
                stall_seen = stall_ticket;
                stall_left = STALL_LEN;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    task send_byte(input logic [7:0] c, input bit last);
        if ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        char_code <= c;
        source_last <= last;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sb.note_byte(c, last);
        bytes_sent++;
    endtask

    task send_text(input string s, input bit last_flag);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last_flag && (i == s.len() - 1));
    endtask

    function automatic string blank_run();
        string s;
        s = "";
        repeat ($urandom_range(1, 2)) s = {s, string'(blanks[$urandom_range(5)])};
        return s;
    endfunction

    function automatic string make_piece(output bit is_word);
        string s;
        s = "";
        is_word = 1;
        case ($urandom_range(9))
            0, 1: s = kw_list[$urandom_range(25)];
            2, 3: begin
                s = string'(id_chars[$urandom_range(12)]);
                repeat ($urandom_range(0, 11))
                    s = {s, string'(id_chars[$urandom_range(id_chars.len() - 1)])};
            end
            4, 5: begin
                repeat ($urandom_range(1, 5)) s = {s, string'(id_chars[$urandom_range(13, 22)])};
            end
            6: begin
                s = op_pairs[$urandom_range(10)];
                is_word = 0;
            end
            default: begin
                s = string'(op_singles[$urandom_range(op_singles.len() - 1)]);
                is_word = 0;
            end
        endcase
        return s;
    endfunction

    task send_source();
        string src;
        string piece;
        bit prev_word;
        bit cur_word;
        src = "";
        prev_word = 0;
        repeat ($urandom_range(1, 10)) begin
            piece = make_piece(cur_word);
            if ((prev_word && cur_word) || $urandom_range(2) == 0) src = {src, blank_run()};
            src = {src, piece};
            prev_word = cur_word;
        end
        if ($urandom_range(3) == 0) src = {src, blank_run()};
        send_text(src, 1);
    endtask

    initial begin
        string tail;
        sb = new;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("let _q9+=12\t 34;", 0);
        send_text("Struct[a]&&b||c.", 1);

        while (bytes_sent < 140) send_source();
        send_idle = 60;
        recv_idle = 27;
        while (bytes_sent < 280) send_source();
        send_idle = 0;
        recv_idle = 0;
        stall_ticket++;
        while (bytes_sent < ITEMS) send_source();

        // one error halts the block, everything after it is dropped
        case ($urandom_range(4))
            0: tail = "12 ,";
            1: tail = "x:";
            2: tail = "a&b ";
            3: tail = "7q ";
            default: begin
                tail = "x ";
                tail.putc(1, 8'h80 | 8'($urandom_range(127)));
            end
        endcase
        send_text(tail, 0);
        repeat (40) send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
        in_valid <= 1'b0;

        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.pending.size() > 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
